/* hdl/mt19937_random_source_assert.svh */
// Assertion macros shared by the random source.
`ifndef MT19937_RANDOM_SOURCE_ASSERT_SVH
`define MT19937_RANDOM_SOURCE_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define MT_ASSERT_IMPLY(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("implication failed");

// Checks that a condition implies a consequence in the next cycle.
`define MT_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

/* hdl/mtrs_pkg.sv */
package mtrs_pkg;

   localparam int unsigned MtN = 624;
   localparam int unsigned MtM = 397;
   localparam logic [31:0] MtMatrix = 32'h9908_B0DF;
   localparam logic [31:0] MtInitMult = 32'd1812433253;
   localparam logic [31:0] SeedOffset = 32'd1;

   localparam logic [1:0] OpRaw = 2'd0;
   localparam logic [1:0] OpFrac = 2'd1;
   localparam logic [1:0] OpPerm = 2'd2;
   localparam logic [1:0] OpNone = 2'd3;

   typedef logic [9:0] word_index_type;

   typedef enum logic [3:0] {
      ST_INIT_RD,
      ST_INIT_MUL,
      ST_INIT_WR,
      ST_IDLE,
      ST_REGEN_RD0,
      ST_REGEN_RD1,
      ST_REGEN_RD2,
      ST_REGEN_WR,
      ST_WORD_RD,
      ST_WORD_USE,
      ST_PERM_FILL,
      ST_PERM_MOD,
      ST_PERM_SWAP,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic [31:0] dividend;
      logic [6:0] divisor;
   } div_cmd_type;

   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & 32'h9D2C_5680);
      y = y ^ ((y << 15) & 32'hEFC6_0000);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

/* hdl/mtrs_divider.sv */
module mtrs_divider (
   input  logic clock,
   input  logic reset,
   input  mtrs_pkg::div_cmd_type cmd,
   output logic busy,
   output logic [5:0] remainder
);
   import mtrs_pkg::*;

   logic [31:0] quo_ff, quo_in;
   logic [6:0] rem_ff, rem_in;
   logic [6:0] den_ff, den_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [7:0] trial;

   assign trial = {rem_ff, quo_ff[31]} - {1'b0, den_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (cmd.start) begin
         quo_in = cmd.dividend;
         rem_in = '0;
         den_in = cmd.divisor;
         cnt_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], 1'b0};
         if (!trial[7]) begin
            rem_in = trial[6:0];
         end else begin
            rem_in = {rem_ff[5:0], quo_ff[31]};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign remainder = rem_ff[5:0];
endmodule

/* hdl/mt19937_random_source.sv */
// MT19937 source. After reset and after every seed write the 624-word state is
// rebuilt from seed+1, one word at a time, with no request taken meanwhile. A
// request for raw words or fractions then reads one state word per result, and
// the state is regenerated whenever all 624 words have been used. A permutation
// fills one entry per cycle, then for each entry draws a word, finds its
// remainder bit by bit and swaps two entries, and then emits the entries. A new
// request is taken only once the last one is done. A stalled result holds the
// sequencer until it is taken. The single-port state memory and the divider set
// the pace.
module mt19937_random_source #(
   parameter int unsigned MAX_COUNT = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [31:0] csr_seed_value,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_op,
   input  logic [6:0] req_count,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [32:0] rsp_value,
   output logic rsp_last
);
   import mtrs_pkg::*;

   localparam int unsigned PermW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;

   state_type state_ff, state_in;
   logic [31:0] words [MtN];
   word_index_type addr;
   logic wr_en;
   logic [31:0] wr_data, rd_ff;
   word_index_type k_ff, k_in;
   word_index_type idx_ff, idx_in;
   logic [31:0] prev_ff, prev_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [1:0] op_ff, op_in;
   logic [6:0] cnt_ff, cnt_in, i_ff, i_in;
   logic [PermW-1:0] perm [MAX_COUNT];
   logic [PermW-1:0] perm_rd_ff;
   logic perm_we;
   logic [PermW-1:0] perm_wa, perm_wd, perm_ra;
   logic swap_phase_ff;
   logic [PermW-1:0] ent_i_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [32:0] rsp_value_ff, rsp_value_in;
   logic rsp_last_ff, rsp_last_in;
   div_cmd_type div_cmd;
   logic div_busy;
   logic [5:0] div_rem;
   logic [6:0] sat_count;
   logic [31:0] tempered, y, v, xs;
   logic [63:0] prod;

   mtrs_divider u_div (
      .clock(clock), .reset(reset), .cmd(div_cmd), .busy(div_busy), .remainder(div_rem)
   );

   assign sat_count = (req_count > 7'(MAX_COUNT)) ? 7'(MAX_COUNT) : req_count;
   assign tempered = temper(rd_ff);
   assign xs = prev_ff ^ (prev_ff >> 30);
   assign prod = MtInitMult * xs;
   assign y = {t0_ff[31], t1_ff[30:0]};
   assign v = rd_ff ^ (y >> 1) ^ (y[0] ? MtMatrix : 32'd0);

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      idx_in = idx_ff;
      prev_in = prev_ff;
      t0_in = t0_ff;
      t1_in = t1_ff;
      op_in = op_ff;
      cnt_in = cnt_ff;
      i_in = i_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         ST_INIT_RD: begin
            state_in = ST_INIT_MUL;
         end
         ST_INIT_MUL: begin
            prev_in = prod[31:0] + 32'(k_ff);
            state_in = ST_INIT_WR;
         end
         ST_INIT_WR: begin
            if (k_ff == word_index_type'(MtN - 1)) begin
               idx_in = word_index_type'(MtN);
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + 10'd1;
               state_in = ST_INIT_RD;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_op;
               cnt_in = sat_count;
               i_in = '0;
               if (sat_count == 7'd0 || req_op == OpNone) begin
                  state_in = ST_IDLE;
               end else if (req_op == OpPerm) begin
                  state_in = ST_PERM_FILL;
               end else begin
                  state_in = ST_WORD_RD;
               end
            end
         end
         ST_PERM_FILL: begin
            if (i_ff == cnt_ff - 7'd1) begin
               i_in = '0;
               state_in = ST_WORD_RD;
            end else begin
               i_in = i_ff + 7'd1;
            end
         end
         ST_WORD_RD: begin
            if (idx_ff == word_index_type'(MtN)) begin
               k_in = '0;
               state_in = ST_REGEN_RD0;
            end else begin
               state_in = ST_WORD_USE;
            end
         end
         ST_REGEN_RD0: begin
            state_in = ST_REGEN_RD1;
         end
         ST_REGEN_RD1: begin
            t0_in = rd_ff;
            state_in = ST_REGEN_RD2;
         end
         ST_REGEN_RD2: begin
            t1_in = rd_ff;
            state_in = ST_REGEN_WR;
         end
         ST_REGEN_WR: begin
            if (k_ff == word_index_type'(MtN - 1)) begin
               idx_in = '0;
               state_in = ST_WORD_RD;
            end else begin
               k_in = k_ff + 10'd1;
               state_in = ST_REGEN_RD0;
            end
         end
         ST_WORD_USE: begin
            if (op_ff == OpPerm) begin
               idx_in = idx_ff + 10'd1;
               state_in = ST_PERM_MOD;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               idx_in = idx_ff + 10'd1;
               rsp_valid_in = 1'b1;
               rsp_value_in = {1'b0, tempered};
               if (op_ff == OpFrac && tempered == 32'hFFFF_FFFF) begin
                  rsp_value_in = 33'h1_0000_0000;
               end
               rsp_last_in = (i_ff == cnt_ff - 7'd1);
               if (i_ff == cnt_ff - 7'd1) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in = i_ff + 7'd1;
                  state_in = ST_WORD_RD;
               end
            end
         end
         ST_PERM_MOD: begin
            if (!div_cmd.start && !div_busy) begin
               state_in = ST_PERM_SWAP;
            end
         end
         ST_PERM_SWAP: begin
            if (swap_phase_ff) begin
               if (i_ff == cnt_ff - 7'd1) begin
                  i_in = '0;
                  state_in = ST_EMIT_RD;
               end else begin
                  i_in = i_ff + 7'd1;
                  state_in = ST_WORD_RD;
               end
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = 33'(perm_rd_ff);
               rsp_last_in = (i_ff == cnt_ff - 7'd1);
               if (i_ff == cnt_ff - 7'd1) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in = i_ff + 7'd1;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_write) begin
         k_in = '0;
         prev_in = csr_seed_value + SeedOffset;
         state_in = ST_INIT_WR;
      end
   end

   // The swap of entry i with entry j writes in two steps: entry j, read into
   // perm_rd_ff, is written to i, then entry i, held in ent_i_ff, is written to j.
   always_comb begin
      addr = k_ff;
      wr_en = 1'b0;
      wr_data = prev_ff;
      div_cmd = '0;
      perm_we = 1'b0;
      perm_wa = i_ff[PermW-1:0];
      perm_wd = i_ff[PermW-1:0];
      perm_ra = i_ff[PermW-1:0];
      case (state_ff)
         ST_INIT_RD: begin
            addr = k_ff;
         end
         ST_INIT_WR: begin
            wr_en = 1'b1;
            addr = k_ff;
         end
         ST_REGEN_RD0: begin
            addr = k_ff;
         end
         ST_REGEN_RD1: begin
            addr = (k_ff == word_index_type'(MtN - 1)) ? '0 : k_ff + 10'd1;
         end
         ST_REGEN_RD2: begin
            addr = (k_ff >= word_index_type'(MtN - MtM)) ?
               k_ff - word_index_type'(MtN - MtM) : k_ff + word_index_type'(MtM);
         end
         ST_REGEN_WR: begin
            addr = k_ff;
            wr_en = 1'b1;
            wr_data = v;
         end
         ST_WORD_RD: begin
            addr = idx_ff;
         end
         ST_PERM_FILL: begin
            perm_we = 1'b1;
         end
         ST_WORD_USE: begin
            addr = idx_ff;
            if (op_ff == OpPerm) begin
               div_cmd.start = 1'b1;
               div_cmd.dividend = tempered;
               div_cmd.divisor = cnt_ff;
            end
         end
         ST_PERM_MOD: begin
            perm_ra = div_rem[PermW-1:0];
         end
         ST_PERM_SWAP: begin
            perm_we = 1'b1;
            if (!swap_phase_ff) begin
               perm_wa = i_ff[PermW-1:0];
               perm_wd = perm_rd_ff;
            end else begin
               perm_wa = div_rem[PermW-1:0];
               perm_wd = ent_i_ff;
            end
         end
         default: begin
            addr = k_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         words[addr] <= wr_data;
      end
      rd_ff <= words[addr];
      if (perm_we) begin
         perm[perm_wa] <= perm_wd;
      end
      perm_rd_ff <= perm[perm_ra];
      if (state_ff == ST_WORD_USE) begin
         ent_i_ff <= perm[i_ff[PermW-1:0]];
      end
      swap_phase_ff <= (state_ff == ST_PERM_SWAP) && !swap_phase_ff;
   end

   // The init write stores prev_ff and the next iteration reads it straight
   // from the register, so no memory read is needed there.
   always_ff @(posedge clock) begin
      t0_ff <= t0_in;
      t1_ff <= t1_in;
      op_ff <= op_in;
      cnt_ff <= cnt_in;
      i_ff <= i_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff <= ST_INIT_WR;
         k_ff <= '0;
         prev_ff <= 32'd0 + SeedOffset;
         idx_ff <= word_index_type'(MtN);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         prev_ff <= prev_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || csr_write;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last = rsp_last_ff;

`include "mt19937_random_source_assert.svh"

   `MT_ASSERT_IMPLY(a_no_req_when_busy, clock, reset, state_ff != ST_IDLE, req_stall)
   `MT_ASSERT_NEXT(a_out_held, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_value))
   `MT_ASSERT_IMPLY(a_idx_bound, clock, reset, 1'b1, idx_ff <= word_index_type'(MtN))
endmodule

/* tb/sv/tb.sv */
module tb;
   import mtrs_pkg::*;

   localparam int unsigned WatchdogLimit = 40000;
   localparam int unsigned SettleCycles = 4000;
   localparam int unsigned RandomItems = 370;
   localparam logic [31:0] UpperMask = 32'h8000_0000;
   localparam logic [31:0] LowerMask = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [32:0] value;
      logic last;
   } result_type;

   typedef struct {
      logic [1:0] op;
      logic [6:0] count;
      logic pinned;
      logic [32:0] first_value;
   } stimulus_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [31:0] csr_seed_value = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_op = OpRaw;
   logic [6:0] req_count = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [32:0] rsp_value;
   logic rsp_last;

   logic [31:0] twister_state [MtN];
   int unsigned twister_pos;
   result_type expected_results [$];
   logic pin_first = 1'b0;
   logic [32:0] pin_value = '0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;

   stimulus_row_type directed [15] = '{
      '{OpRaw, 7'd1, 1'b1, 33'd1791095845},
      '{OpRaw, 7'd1, 1'b1, 33'd4282876139},
      '{OpRaw, 7'd0, 1'b0, 33'd0},
      '{OpNone, 7'd5, 1'b0, 33'd0},
      '{OpPerm, 7'd1, 1'b1, 33'd0},
      '{OpRaw, 7'd64, 1'b0, 33'd0},
      '{OpFrac, 7'd64, 1'b0, 33'd0},
      '{OpPerm, 7'd2, 1'b0, 33'd0},
      '{OpPerm, 7'd64, 1'b0, 33'd0},
      '{OpRaw, 7'd127, 1'b0, 33'd0},
      '{OpPerm, 7'd65, 1'b0, 33'd0},
      '{OpFrac, 7'd3, 1'b0, 33'd0},
      '{OpNone, 7'd0, 1'b0, 33'd0},
      '{OpFrac, 7'd100, 1'b0, 33'd0},
      '{OpNone, 7'd127, 1'b0, 33'd0}
   };

   mt19937_random_source u_top (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_seed_value(csr_seed_value),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_count(req_count),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_value(rsp_value),
      .rsp_last(rsp_last)
   );

   always #6 clock = ~clock;

   task automatic seed_twister(input logic [31:0] s);
      logic [31:0] prev;
      twister_state[0] = s;
      for (int k = 1; k < MtN; k++) begin
         prev = twister_state[k - 1];
         twister_state[k] = MtInitMult * (prev ^ (prev >> 30)) + 32'(k);
      end
      twister_pos = MtN;
   endtask

   function automatic logic [31:0] draw_word();
      logic [31:0] y;
      logic [31:0] v;
      if (twister_pos >= MtN) begin
         for (int k = 0; k < MtN; k++) begin
            y = (twister_state[k] & UpperMask) | (twister_state[(k + 1) % MtN] & LowerMask);
            v = twister_state[(k + MtM) % MtN] ^ (y >> 1);
            if (y[0]) begin
               v = v ^ MtMatrix;
            end
            twister_state[k] = v;
         end
         twister_pos = 0;
      end
      y = twister_state[twister_pos];
      twister_pos++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & 32'h9D2C_5680);
      y = y ^ ((y << 15) & 32'hEFC6_0000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   task automatic predict_request(input logic [1:0] op, input logic [6:0] count_in);
      int unsigned n;
      int unsigned j;
      logic [5:0] perm [64];
      logic [5:0] t;
      logic [31:0] w;
      result_type r;
      n = (count_in > 64) ? 64 : count_in;
      if (n == 0 || op == OpNone) begin
         return;
      end
      if (op == OpPerm) begin
         for (int i = 0; i < n; i++) begin
            perm[i] = 6'(i);
         end
         for (int i = 0; i < n; i++) begin
            j = draw_word() % n;
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
         end
      end
      for (int i = 0; i < n; i++) begin
         if (op == OpPerm) begin
            r.value = {27'd0, perm[i]};
         end else begin
            w = draw_word();
            r.value = {1'b0, w};
            if (op == OpFrac && w == 32'hFFFF_FFFF) begin
               r.value = 33'h1_0000_0000;
            end
         end
         if (i == 0 && pin_first) begin
            r.value = pin_value;
         end
         r.last = (i + 1 == n);
         expected_results.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (req_valid && !req_stall) begin
            predict_request(req_op, req_count);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Unexpected result: value %h last %b", rsp_value, rsp_last);
               end
            end else begin
               if (rsp_value !== expected_results[0].value ||
                   rsp_last !== expected_results[0].last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Mismatch: expected value %h last %b, got value %h last %b",
                              expected_results[0].value, expected_results[0].last,
                              rsp_value, rsp_last);
                  end
               end
               void'(expected_results.pop_front());
            end
         end
         if (quiet_cycles >= WatchdogLimit) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic send_request(input logic [1:0] op, input logic [6:0] count,
                               input logic pinned, input logic [32:0] first_value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_op = op;
      req_count = count;
      pin_first = pinned;
      pin_value = first_value;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic drain_results();
      while (expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      csr_seed_value = value;
      csr_write = 1'b1;
      seed_twister(value + SeedOffset);
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic send_random_request();
      logic [1:0] op;
      logic [6:0] count;
      int unsigned pick;
      pick = $urandom_range(9);
      op = (pick < 3) ? OpRaw : (pick < 6) ? OpFrac : (pick < 9) ? OpPerm : OpNone;
      pick = $urandom_range(99);
      if (pick < 85) begin
         count = 7'($urandom_range(8));
      end else if (pick < 97) begin
         count = 7'($urandom_range(64, 9));
      end else begin
         count = 7'($urandom_range(127, 65));
      end
      send_request(op, count, 1'b0, '0);
   endtask

   initial begin
      seed_twister(SeedOffset);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle_pct = 36;
      recv_idle_pct = 86;
      foreach (directed[i]) begin
         send_request(directed[i].op, directed[i].count, directed[i].pinned,
                      directed[i].first_value);
      end
      for (int phase = 0; phase < 3; phase++) begin
         req_valid = 1'b0;
         pin_first = 1'b0;
         drain_results();
         case (phase)
            0: begin
               write_seed(32'hFFFF_FFFF);
            end
            1: begin
               send_idle_pct = 86;
               recv_idle_pct = 36;
               write_seed(32'h0000_0000);
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               write_seed($urandom);
            end
         endcase
         for (int n = 0; n < RandomItems / 3; n++) begin
            send_random_request();
         end
      end
      req_valid = 1'b0;
      while (expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (200) @(negedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
